FILE: rtl/core/iorwd_pkg.sv
// Shared types and constants for the in-order release block.
package iorwd_pkg;

  localparam int unsigned WINDOW_DEFAULT = 64;
  localparam int unsigned QUEUE_DEPTH    = 2;

  localparam logic [1:0] OP_RESULT = 2'd0;
  localparam logic [1:0] OP_DROP   = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_STALE  = 2'd1;
  localparam logic [1:0] STAT_BEYOND = 2'd2;

  typedef struct packed {
    logic is_result;
    logic is_drop;
    logic is_tick;
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] seq_id;
    logic [31:0] payload;
  } item_t;

endpackage

FILE: rtl/core/iorwd_front.sv
// Front end: accepts transactions, decodes the opcode, queues them for the back end.
module iorwd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          opcode,
  input  logic [31:0]         seq_id,
  input  logic [31:0]         payload,
  output logic                q_valid,
  input  logic                q_ready,
  output iorwd_pkg::item_t    q_item
);
  import iorwd_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  item_t           entries [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  item_t           dec;
  logic            push;
  logic            pop;

  always_comb begin
    dec                = '0;
    dec.kind.is_result = (opcode == OP_RESULT);
    dec.kind.is_drop   = (opcode == OP_DROP);
    dec.kind.is_tick   = (opcode == OP_TICK);
    dec.seq_id         = seq_id;
    dec.payload        = payload;
  end

  assign in_stall = (count == CW'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign pop      = q_valid && q_ready;
  assign q_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/iorwd_back.sv
// Back end: window check, mark and payload store, release and skip walk, result register.
module iorwd_back #(
  parameter int unsigned WINDOW = iorwd_pkg::WINDOW_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  iorwd_pkg::item_t    q_item,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                released,
  output logic [31:0]         released_id,
  output logic [31:0]         released_payload,
  output logic [1:0]          status,
  output logic [31:0]         expected_id
);
  import iorwd_pkg::*;

  localparam int unsigned SW = $clog2(WINDOW);
  localparam int unsigned CW = $clog2(WINDOW + 1);
  localparam logic [63:0] TWO32 = 64'h1_0000_0000;
  // 2^32 mod WINDOW: slot offset when a number wraps past zero
  localparam int unsigned WRAP_OFS = int'(TWO32 % WINDOW);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLASS = 3'd1;
  localparam logic [2:0] ST_ACT   = 3'd2;
  localparam logic [2:0] ST_SKIP  = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]        state;
  kind_t             kind;
  logic [31:0]       pay;
  logic [31:0]       delta;
  logic              borrow;
  logic [SW:0]       sum;
  logic [1:0]        stat;
  logic [31:0]       expct;
  logic [SW-1:0]     exp_slot;
  logic [WINDOW-1:0] present;
  logic [WINDOW-1:0] dropped;
  logic [31:0]       store [WINDOW];
  logic [31:0]       rd_data;
  logic [CW-1:0]     skip_cnt;
  logic              rel;
  logic [31:0]       rel_id;
  logic [31:0]       rel_pay;

  logic [32:0]       diff;
  logic [SW:0]       slot_a;
  logic [SW:0]       slot_w;
  logic [SW-1:0]     slot;
  logic              adv;
  logic              mem_we;
  logic              out_free;
  logic              skip_go;

  assign q_ready  = (state == ST_IDLE);
  assign diff     = {1'b0, q_item.seq_id} - {1'b0, expct};
  assign out_free = !out_valid || !out_stall;
  assign skip_go  = (skip_cnt < CW'(WINDOW)) && dropped[exp_slot];

  // slot = (exp_slot + delta) mod WINDOW, corrected when the number wrapped past zero
  always_comb begin
    slot_a = (sum >= (SW+1)'(WINDOW)) ? sum - (SW+1)'(WINDOW) : sum;
    if (borrow) begin
      slot_w = (slot_a >= (SW+1)'(WRAP_OFS)) ? slot_a - (SW+1)'(WRAP_OFS)
                                             : slot_a + (SW+1)'(WINDOW - WRAP_OFS);
    end else begin
      slot_w = slot_a;
    end
    slot = slot_w[SW-1:0];
  end

  always_comb begin
    adv    = 1'b0;
    mem_we = 1'b0;
    if (state == ST_ACT) begin
      priority if (kind.is_result) begin
        mem_we = (stat == STAT_OK) && !present[slot];
      end else if (kind.is_drop) begin
        adv = (stat == STAT_OK) && (delta == '0);
      end else if (kind.is_tick) begin
        adv = present[exp_slot];
      end else begin
        // unused opcode: no state change
        adv = 1'b0;
      end
    end else if (state == ST_SKIP) begin
      adv = skip_go;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[slot] <= pay;
    end
    rd_data <= store[exp_slot];
  end

  // item registers and result payload
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          kind    <= q_item.kind;
          pay     <= q_item.payload;
          delta   <= diff[31:0];
          borrow  <= diff[32];
          rel_id  <= '0;
          rel_pay <= '0;
        end
      end
      ST_CLASS: begin
        sum <= {1'b0, exp_slot} + {1'b0, delta[SW-1:0]};
        if (!(kind.is_result || kind.is_drop) || delta < 32'(WINDOW)) begin
          stat <= STAT_OK;
        end else if (delta[31]) begin
          stat <= STAT_STALE;
        end else begin
          stat <= STAT_BEYOND;
        end
      end
      ST_ACT: begin
        skip_cnt <= '0;
        if (kind.is_tick && present[exp_slot]) begin
          rel_id  <= expct;
          rel_pay <= rd_data;
        end
      end
      ST_SKIP: begin
        if (skip_go) begin
          skip_cnt <= skip_cnt + 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          released_id      <= rel_id;
          released_payload <= rel_pay;
          status           <= stat;
          expected_id      <= expct;
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      expct     <= '0;
      exp_slot  <= '0;
      present   <= '0;
      dropped   <= '0;
      rel       <= 1'b0;
      released  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            rel   <= 1'b0;
            state <= ST_CLASS;
          end
        end
        ST_CLASS: state <= ST_ACT;
        ST_ACT: begin
          if (kind.is_result && mem_we) begin
            present[slot] <= 1'b1;
          end
          if (kind.is_drop && stat == STAT_OK && delta != '0) begin
            dropped[slot] <= 1'b1;
          end
          if (kind.is_tick && present[exp_slot]) begin
            rel <= 1'b1;
          end
          state <= kind.is_tick ? ST_SKIP : ST_EMIT;
        end
        ST_SKIP: begin
          if (!skip_go) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            released <= rel;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase

      if (adv) begin
        present[exp_slot] <= 1'b0;
        dropped[exp_slot] <= 1'b0;
        expct             <= expct + 32'd1;
        if (expct == '1 || exp_slot == SW'(WINDOW - 1)) begin
          exp_slot <= '0;
        end else begin
          exp_slot <= exp_slot + 1'b1;
        end
      end

      if (state == ST_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/in_order_release_with_drops.sv
// Top level of the in-order release block: front queue plus release engine.
//
// Reorder window that hands out tagged results strictly in sequence order.
// Each input transaction carries an opcode: result (stores the payload handle
// in the slot of its sequence number, first arrival wins), drop notice
// (advances the expected number at once if it names it, otherwise marks that
// number skipped) or release tick (emits the payload at the expected number if
// present, then steps over every consecutive dropped number). Numbers behind
// the expected one or WINDOW or more ahead of it are ignored and flagged in
// status. Exactly one output transaction follows every input transaction.
// Steps in the release engine: a result, a drop notice or an unused opcode
// passes dequeue, window check, update and output load; a tick adds a skip
// walk after the update over the dropped numbers (at most WINDOW), one per
// cycle through the mark array. A two-entry queue ahead of the
// engine and the output register behind it let input and output stall apart.
// No clearing pass is needed after reset: marks live in flops that reset clears.
module in_order_release_with_drops #(
  parameter int unsigned WINDOW = iorwd_pkg::WINDOW_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [1:0]   opcode,
  input  logic [31:0]  seq_id,
  input  logic [31:0]  payload,
  output logic         out_valid,
  input  logic         out_stall,
  output logic         released,
  output logic [31:0]  released_id,
  output logic [31:0]  released_payload,
  output logic [1:0]   status,
  output logic [31:0]  expected_id
);
  import iorwd_pkg::*;

  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  // accept and decode, queue toward the engine
  iorwd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .opcode   (opcode),
    .seq_id   (seq_id),
    .payload  (payload),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  // window check, marks, payload store, release and skip walk
  iorwd_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_valid),
    .q_ready          (q_ready),
    .q_item           (q_item),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .released         (released),
    .released_id      (released_id),
    .released_payload (released_payload),
    .status           (status),
    .expected_id      (expected_id)
  );

endmodule

FILE: rtl/core/iorwd_checker.sv
// Port-level checks for the in-order release block, bound to the top level.
module iorwd_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         out_valid,
  input  logic         out_stall,
  input  logic         released,
  input  logic [31:0]  released_id,
  input  logic [31:0]  released_payload,
  input  logic [1:0]   status,
  input  logic [31:0]  expected_id
);
  import iorwd_pkg::*;

  // a release comes only from a tick, whose status is always ok
  a_rel_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && released |-> status == STAT_OK)
    else $error("release with non-ok status");

  // a release always moves the expected number past the emitted one
  a_rel_adv: assert property (@(posedge clk) disable iff (rst)
    out_valid && released |-> expected_id != released_id)
    else $error("expected number did not advance on release");

  // without a release the release fields are zero
  a_norel_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !released |-> released_id == '0 && released_payload == '0)
    else $error("release fields nonzero without release");

  // a stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(expected_id) && $stable(status))
    else $error("stalled output changed");

endmodule

bind in_order_release_with_drops iorwd_checker u_iorwd_checker (.*);

FILE: test/in_order_release_with_drops_tb.sv
// Self-checking testbench for the in-order release block with drop notices.
import iorwd_pkg::*;

class reorder_checker;
  localparam int unsigned WIN = WINDOW_DEFAULT;

  typedef struct packed {
    logic        released;
    logic [31:0] released_id;
    logic [31:0] released_payload;
    logic [1:0]  status;
    logic [31:0] expected_id;
  } release_t;

  bit [31:0] next_exp;
  bit        present[WIN];
  bit        dropped[WIN];
  bit [31:0] handle_store[WIN];
  release_t  awaited_releases[$];

  int errors;
  int n_in;
  int n_checked;
  int n_released;
  int n_skipped;
  int n_outside;

  function new();
    next_exp = '0;
    foreach (present[i]) begin
      present[i] = 1'b0;
      dropped[i] = 1'b0;
      handle_store[i] = '0;
    end
  endfunction

  function int slot_of(bit [31:0] sid);
    return int'(sid % WIN);
  endfunction

  // Distance ahead of the awaited number decides in-window, stale or beyond.
  function logic [1:0] window_status(bit [31:0] sid);
    bit [31:0] ahead;
    ahead = sid - next_exp;
    if (ahead < WIN) return STAT_OK;
    if (ahead[31]) return STAT_STALE;
    return STAT_BEYOND;
  endfunction

  function void step_over();
    int s;
    s = slot_of(next_exp);
    present[s] = 1'b0;
    dropped[s] = 1'b0;
    next_exp = next_exp + 1;
  endfunction

  function int pending();
    return awaited_releases.size();
  endfunction

  // Predict the one output transaction caused by an accepted input.
  function void note_transaction(logic [1:0] op, logic [31:0] sid, logic [31:0] pay);
    release_t r;
    int       s;
    r = '0;
    n_in++;
    case (op)
      OP_RESULT: begin
        r.status = window_status(sid);
        if (r.status == STAT_OK) begin
          s = slot_of(sid);
          if (!present[s]) begin
            present[s] = 1'b1;
            handle_store[s] = pay;
          end
        end
      end
      OP_DROP: begin
        r.status = window_status(sid);
        if (r.status == STAT_OK) begin
          if (sid == next_exp) step_over();
          else dropped[slot_of(sid)] = 1'b1;
        end
      end
      OP_TICK: begin
        s = slot_of(next_exp);
        if (present[s]) begin
          r.released = 1'b1;
          r.released_id = next_exp;
          r.released_payload = handle_store[s];
          n_released++;
          step_over();
        end
        for (int n = 0; n < WIN; n++) begin
          if (!dropped[slot_of(next_exp)]) break;
          n_skipped++;
          step_over();
        end
      end
      default: ;
    endcase
    if (r.status != STAT_OK) n_outside++;
    r.expected_id = next_exp;
    awaited_releases.push_back(r);
  endfunction

  function void check_output(logic rel, logic [31:0] rid, logic [31:0] rpay,
                             logic [1:0] st, logic [31:0] eid);
    release_t w;
    n_checked++;
    if (awaited_releases.size() == 0) begin
      $error("output transaction with none awaited");
      errors++;
      return;
    end
    w = awaited_releases.pop_front();
    if (rel !== w.released) begin
      $error("released: expected %0d, got %0d", w.released, rel);
      errors++;
    end
    if (rid !== w.released_id) begin
      $error("released_id: expected 0x%08h, got 0x%08h", w.released_id, rid);
      errors++;
    end
    if (rpay !== w.released_payload) begin
      $error("released_payload: expected 0x%08h, got 0x%08h", w.released_payload, rpay);
      errors++;
    end
    if (st !== w.status) begin
      $error("status: expected %0d, got %0d", w.status, st);
      errors++;
    end
    if (eid !== w.expected_id) begin
      $error("expected_id: expected 0x%08h, got 0x%08h", w.expected_id, eid);
      errors++;
    end
  endfunction
endclass

module in_order_release_with_drops_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WIN = WINDOW_DEFAULT;
  localparam logic [1:0]  OP_SPARE = 2'd3;     // unused opcode, must be a no-op
  localparam int          HOLD_CYCLES = 300;   // long output hold-off
  localparam int          QUIET_LIMIT = 4000;  // cycles with no handshake at all
  localparam int          TAIL_CYCLES = 150;   // outlasts the longest tick, a full-window skip walk

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode = OP_RESULT;
  logic [31:0] seq_id = '0;
  logic [31:0] payload = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        released;
  logic [31:0] released_id;
  logic [31:0] released_payload;
  logic [1:0]  status;
  logic [31:0] expected_id;

  reorder_checker sb = new();

  // Idle/stall mix of the current phase, in percent.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // One-shot long hold-off on the output side, timed in the receiver process.
  logic hold_go = 1'b0;
  logic hold_started = 1'b0;
  int   hold_left = 0;
  int   quiet_cycles = 0;

  in_order_release_with_drops #(.WINDOW(WIN)) u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .opcode           (opcode),
    .seq_id           (seq_id),
    .payload          (payload),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .released         (released),
    .released_id      (released_id),
    .released_payload (released_payload),
    .status           (status),
    .expected_id      (expected_id)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver: check every accepted output transaction, then pick next stall.
  // Values are read at the edge, before any NBA of this step lands.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_output(released, released_id, released_payload, status, expected_id);
    if (hold_go && !hold_started) begin
      hold_started <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      out_stall    <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog: a long stretch with no handshake on either side means a hang.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offer one transaction and hold it until accepted. valid stays high into
  // the next transaction unless a random gap is drawn, so it is never
  // lowered and raised in the same step.
  task automatic send_item(input logic [1:0] op, input logic [31:0] sid,
                           input logic [31:0] pay);
    in_valid <= 1'b1;
    opcode   <= op;
    seq_id   <= sid;
    payload  <= pay;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_transaction(op, sid, pay);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
  endtask

  // Sender pause: nothing offered until every output has come back.
  task automatic wait_all_released();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Every slot ends up dropped: the awaited number itself (marked while it
  // was still ahead) plus the WIN-1 numbers after it, so one tick steps
  // over the whole window and hits the skip bound exactly.
  task automatic full_window_skip();
    logic [31:0] base;
    base = sb.next_exp;
    send_item(OP_DROP, base + 1, $urandom);
    send_item(OP_DROP, base, $urandom);
    for (int i = 2; i <= WIN; i++) send_item(OP_DROP, base + i, $urandom);
    send_item(OP_TICK, $urandom, $urandom);
  endtask

  // Mostly well-formed bursts around the awaited number, so releases and
  // skip runs happen often; the rest is window edges and plain noise.
  task automatic run_random(input int n_items);
    int          done;
    int          pick;
    int          k;
    int          j;
    logic [31:0] base;
    logic [31:0] tmp;
    logic [31:0] ids[$];
    done = 0;
    while (done < n_items) begin
      pick = $urandom_range(99);
      base = sb.next_exp;
      if (pick < 55) begin
        // results and drops for the next few numbers, shuffled, then ticks
        k = $urandom_range(1, 8);
        ids.delete();
        for (int i = 0; i < k; i++) ids.push_back(base + i);
        for (int i = 0; i < k; i++) begin
          j = $urandom_range(i, k - 1);
          tmp = ids[i];
          ids[i] = ids[j];
          ids[j] = tmp;
        end
        foreach (ids[i]) begin
          j = $urandom_range(99);
          if (j < 70) begin
            send_item(OP_RESULT, ids[i], $urandom);
          end else if (j < 85) begin
            send_item(OP_DROP, ids[i], $urandom);
          end else begin
            // duplicate: the second handle must lose
            send_item(OP_RESULT, ids[i], $urandom);
            send_item(OP_RESULT, ids[i], $urandom);
            done++;
          end
        end
        j = $urandom_range(1, k + 1);
        for (int i = 0; i < j; i++) send_item(OP_TICK, $urandom, $urandom);
        done += k + j;
      end else if (pick < 65) begin
        // scattered numbers anywhere in the window
        k = $urandom_range(1, 4);
        for (int i = 0; i < k; i++)
          send_item($urandom_range(1) ? OP_RESULT : OP_DROP,
                    base + $urandom_range(WIN - 1), $urandom);
        done += k;
      end else if (pick < 75) begin
        // skip run: drops ahead, then the awaited number resolved, then a tick
        k = $urandom_range(1, 20);
        for (int i = 1; i <= k; i++) send_item(OP_DROP, base + i, $urandom);
        if ($urandom_range(1)) send_item(OP_RESULT, base, $urandom);
        else send_item(OP_DROP, base, $urandom);
        send_item(OP_TICK, $urandom, $urandom);
        done += k + 2;
      end else if (pick < 77) begin
        full_window_skip();
        done += WIN + 2;
      end else if (pick < 84) begin
        send_item(OP_TICK, $urandom, $urandom);
        done++;
      end else if (pick < 92) begin
        // window edges on both sides, including the half-range split
        case ($urandom_range(5))
          0:       tmp = base - 1;
          1:       tmp = base + WIN;
          2:       tmp = base + WIN - 1;
          3:       tmp = base + 32'h7FFF_FFFF;
          4:       tmp = base + 32'h8000_0000;
          default: tmp = base;
        endcase
        send_item($urandom_range(1) ? OP_RESULT : OP_DROP, tmp, $urandom);
        done++;
      end else begin
        // noise: any opcode, any number; mostly ignored, not counted
        send_item(2'($urandom_range(3)), $urandom, $urandom);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, awaited number tracked in the notes.
    send_item(OP_TICK, '0, '0);                        // empty window: nothing
    send_item(OP_RESULT, 32'd0, 32'hFFFF_FFFF);
    send_item(OP_RESULT, 32'd0, 32'h0000_0000);        // duplicate keeps first
    send_item(OP_TICK, '0, '0);                        // release 0, awaiting 1
    send_item(OP_DROP, 32'd1, '0);                     // drop of awaited: now 2
    send_item(OP_RESULT, 32'd3, 32'hA5A5_A5A5);
    send_item(OP_DROP, 32'd2, '0);                     // awaited 3, no skip yet
    send_item(OP_DROP, 32'd4, '0);
    send_item(OP_DROP, 32'd5, '0);
    send_item(OP_RESULT, 32'd5, 32'h1234_5678);        // present and dropped
    send_item(OP_TICK, '0, '0);                        // release 3, skip 4 and 5
    send_item(OP_RESULT, 32'd69, 32'h5A5A_5A5A);       // last number in window
    send_item(OP_RESULT, 32'd70, 32'hFFFF_0000);       // one beyond
    send_item(OP_DROP, 32'd70, '0);                    // beyond
    send_item(OP_RESULT, 32'hFFFF_FFFF, 32'h0000_FFFF); // just behind zero
    send_item(OP_DROP, 32'd5, '0);                     // stale
    send_item(OP_RESULT, 32'd6 + 32'h7FFF_FFFF, 32'd1); // farthest beyond
    send_item(OP_RESULT, 32'd6 + 32'h8000_0000, 32'd2); // nearest stale
    send_item(OP_SPARE, 32'd6, 32'hFFFF_FFFF);         // no state change
    send_item(OP_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // awaited 6 absent
    send_item(OP_DROP, 32'd6, '0);
    send_item(OP_TICK, '0, '0);
    wait_all_released();

    // Back-to-back, with a long output hold-off that fills the block up
    // and pushes back on the input.
    hold_go <= 1'b1;
    run_random(225);
    wait_all_released();

    send_idle_pct = 83;
    recv_stall_pct = 0;
    run_random(175);
    wait_all_released();

    send_idle_pct = 0;
    recv_stall_pct = 83;
    run_random(175);
    wait_all_released();

    send_idle_pct = 25;
    recv_stall_pct = 25;
    full_window_skip();
    run_random(175);
    wait_all_released();

    // Nothing more should come out.
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d input transactions, %0d outputs checked: %0d releases,",
             sb.n_in, sb.n_checked, sb.n_released);
    $display("%0d dropped numbers stepped over, %0d out-of-window, four idle/stall mixes",
             sb.n_skipped, sb.n_outside);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
